/* hw/rtl/frame_credit_latency_monitor_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the frame credit latency monitor
// Concurrent checks that are clocked by i_clk and are quiet while reset is low.
// ----------------------------------------------------------------------------
`ifndef FRAME_CREDIT_LATENCY_MONITOR_TOP_MACROS_SVH
`define FRAME_CREDIT_LATENCY_MONITOR_TOP_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define FCLM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// When the trigger holds, the consequence must hold in the next cycle.
`define FCLM_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/fclm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fclm_pkg
// Shared types and constants for the frame credit latency monitor.
// ----------------------------------------------------------------------------
package fclm_pkg;

    // Default sizes of the stores and of the time stamps.
    localparam int HISTORY_DEPTH_DEF = 20;
    localparam int FIFO_DEPTH_DEF    = 64;
    localparam int TIME_WIDTH_DEF    = 48;

    // Fixed field widths.
    localparam int CNT_W    = 7;
    localparam int CFG_W    = 48;
    localparam int THRESH_W = 48;

    // Register values after reset.
    localparam logic [CNT_W-1:0]    FRAME_LIMIT_RST = 7'd64;
    localparam logic [THRESH_W-1:0] LAT_THRESH_RST  = 48'd1000000;

    // Event kinds.
    typedef enum logic [1:0] {
        MODE_ADD       = 2'd0,
        MODE_DECODED   = 2'd1,
        MODE_REL_REQ   = 2'd2,
        MODE_REL_FIRED = 2'd3
    } t_mode;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_FRAME_LIMIT = 1'b0,
        CFG_LAT_THRESH  = 1'b1
    } t_cfg_idx;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DIV,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

/* hw/rtl/frame_credit_latency_monitor_top.sv */
// Flow: an add or release event and a refused decode pass from the capture through
// the EXEC and DONE states to the output register; an accepted decode also passes
// through the window scan and the one-bit-per-cycle divider that forms the mean.
// A new event is taken only once the previous result has moved into the output
// register, so events wait longer while a waiting result is stalled.
// Reset is synchronous and active low; all counts and statistics clear at once.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frame_credit_latency_monitor_top
// Admits frames into a decoder up to a credit limit and measures the decode
// latency of each frame, with min, max and mean over a window of recent ones.
// ----------------------------------------------------------------------------
`include "frame_credit_latency_monitor_top_macros.svh"

module frame_credit_latency_monitor_top
    import fclm_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int FIFO_DEPTH    = FIFO_DEPTH_DEF,
    parameter int TIME_WIDTH    = TIME_WIDTH_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // Configuration writes
    input  wire logic                  i_cfg_we,
    input  wire logic [0:0]            i_cfg_index,
    input  wire logic [CFG_W-1:0]      i_cfg_data,
    // Event channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [1:0]            i_mode,
    input  wire logic [TIME_WIDTH-1:0] i_now_time,
    // Result channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic                       o_accepted,
    output logic                       o_can_accept,
    output logic [CNT_W-1:0]           o_decoding_count,
    output logic [CNT_W-1:0]           o_decoded_count,
    output logic [TIME_WIDTH-1:0]      o_latency_now,
    output logic                       o_latency_warning,
    output logic [TIME_WIDTH-1:0]      o_min_latency,
    output logic [TIME_WIDTH-1:0]      o_max_latency,
    output logic [TIME_WIDTH-1:0]      o_avg_latency
);

    localparam int FP_W   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int WP_W   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W  = TIME_WIDTH + FILL_W;
    localparam int CMP_W  = (TIME_WIDTH > THRESH_W) ? TIME_WIDTH : THRESH_W;

    // Configuration registers.
    logic [CNT_W-1:0]      r_frame_limit;
    logic [THRESH_W-1:0]   r_lat_thresh;

    // Sequencer and captured event.
    t_state                r_state;
    t_state                n_state;
    t_mode                 r_mode;
    logic [TIME_WIDTH-1:0] r_now;

    // Credit counters and start-time queue pointers.
    logic [CNT_W-1:0]      r_in_dec;
    logic [CNT_W-1:0]      r_done_cnt;
    logic [FP_W-1:0]       r_rd_ptr;
    logic [FP_W-1:0]       r_wr_ptr;

    // Latency window bookkeeping.
    logic [WP_W-1:0]       r_head;
    logic [FILL_W-1:0]     r_fill;
    logic [FILL_W-1:0]     r_scan_idx;
    logic                  r_pend;
    logic                  r_first;
    logic [SUM_W-1:0]      r_sum;
    logic [TIME_WIDTH-1:0] r_lo;
    logic [TIME_WIDTH-1:0] r_hi;

    // Result of the current event and running statistics.
    logic                  r_acc;
    logic [TIME_WIDTH-1:0] r_lat;
    logic                  r_warn;
    logic [TIME_WIDTH-1:0] r_min_seen;
    logic [TIME_WIDTH-1:0] r_max_seen;
    logic [TIME_WIDTH-1:0] r_mean_seen;

    // Memories.
    logic [TIME_WIDTH-1:0] r_fifo_mem [FIFO_DEPTH];
    logic [TIME_WIDTH-1:0] r_fifo_q;
    logic [TIME_WIDTH-1:0] r_win_mem [HISTORY_DEPTH];
    logic [TIME_WIDTH-1:0] r_win_q;

    // Output register.
    logic                  r_out_valid;
    logic                  r_o_acc;
    logic                  r_o_can;
    logic [CNT_W-1:0]      r_o_in_dec;
    logic [CNT_W-1:0]      r_o_done;
    logic [TIME_WIDTH-1:0] r_o_lat;
    logic                  r_o_warn;
    logic [TIME_WIDTH-1:0] r_o_min;
    logic [TIME_WIDTH-1:0] r_o_max;
    logic [TIME_WIDTH-1:0] r_o_avg;

    // Combinational helpers.
    logic                  in_xfer;
    logic                  out_free;
    logic [CNT_W-1:0]      eff_limit;
    logic [CNT_W:0]        total;
    logic                  below_limit;
    logic                  add_ok;
    logic                  dec_ok;
    logic [TIME_WIDTH-1:0] lat_calc;
    logic [WP_W-1:0]       win_raddr;
    logic                  scan_issue;
    logic                  scan_end;
    logic                  div_start;
    logic                  div_done;
    logic [SUM_W-1:0]      div_quo;

    // Credit check against the smaller of the limit and the queue depth, and scan control.
    always_comb begin
        in_xfer     = i_in_valid && !o_in_stall;
        out_free    = !r_out_valid || !i_out_stall;
        eff_limit   = ({2'b00, r_frame_limit} > 9'(FIFO_DEPTH)) ? CNT_W'(FIFO_DEPTH)
                                                                : r_frame_limit;
        total       = {1'b0, r_in_dec} + {1'b0, r_done_cnt};
        below_limit = (total < {1'b0, eff_limit});
        add_ok      = below_limit;
        dec_ok      = (r_in_dec != '0);
        lat_calc    = TIME_WIDTH'(r_now - r_fifo_q);
        scan_issue  = (r_state == S_SCAN) && (r_scan_idx < r_fill);
        scan_end    = (r_state == S_SCAN) && (r_scan_idx == r_fill) && !r_pend;
        div_start   = scan_end;
        win_raddr   = scan_issue ? r_scan_idx[WP_W-1:0] : '0;
    end

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (r_mode == MODE_DECODED && dec_ok) n_state = S_SCAN;
                else n_state = S_DONE;
            end
            S_SCAN: begin
                if (scan_end) n_state = S_DIV;
            end
            S_DIV: begin
                if (div_done) n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_limit <= FRAME_LIMIT_RST;
            r_lat_thresh  <= LAT_THRESH_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_FRAME_LIMIT) r_frame_limit <= i_cfg_data[CNT_W-1:0];
            else r_lat_thresh <= i_cfg_data[THRESH_W-1:0];
        end
    end

    // Capture of the event on its transfer.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_mode <= t_mode'(i_mode);
            r_now  <= i_now_time;
        end
    end

    // Counters, pointers and statistics.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_dec    <= '0;
            r_done_cnt  <= '0;
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_head      <= '0;
            r_fill      <= '0;
            r_scan_idx  <= '0;
            r_pend      <= 1'b0;
            r_first     <= 1'b0;
            r_acc       <= 1'b0;
            r_lat       <= '0;
            r_warn      <= 1'b0;
            r_min_seen  <= '0;
            r_max_seen  <= '0;
            r_mean_seen <= '0;
        end else begin
            unique case (r_state)
                S_EXEC: begin
                    r_acc  <= 1'b0;
                    r_lat  <= '0;
                    r_warn <= 1'b0;
                    unique case (r_mode)
                        MODE_ADD: begin
                            if (add_ok) begin
                                r_wr_ptr <= (r_wr_ptr == FP_W'(FIFO_DEPTH - 1)) ? '0
                                                                               : r_wr_ptr + 1'b1;
                                r_in_dec <= r_in_dec + 1'b1;
                                r_acc    <= 1'b1;
                            end
                        end
                        MODE_DECODED: begin
                            if (dec_ok) begin
                                r_rd_ptr   <= (r_rd_ptr == FP_W'(FIFO_DEPTH - 1)) ? '0
                                                                                 : r_rd_ptr + 1'b1;
                                r_in_dec   <= r_in_dec - 1'b1;
                                r_done_cnt <= r_done_cnt + 1'b1;
                                r_lat      <= lat_calc;
                                r_warn     <= (CMP_W'(lat_calc) > CMP_W'(r_lat_thresh));
                                r_head     <= (r_head == WP_W'(HISTORY_DEPTH - 1)) ? '0
                                                                                  : r_head + 1'b1;
                                if (r_fill < FILL_W'(HISTORY_DEPTH)) r_fill <= r_fill + 1'b1;
                                r_acc      <= 1'b1;
                                r_scan_idx <= '0;
                                r_pend     <= 1'b0;
                                r_first    <= 1'b1;
                            end
                        end
                        MODE_REL_REQ: begin
                            r_acc <= (r_done_cnt != '0);
                        end
                        MODE_REL_FIRED: begin
                            if (r_done_cnt != '0) begin
                                r_done_cnt <= r_done_cnt - 1'b1;
                                r_acc      <= 1'b1;
                            end
                        end
                        default: r_acc <= 1'b0;
                    endcase
                end
                S_SCAN: begin
                    // Issue one window read a cycle, fold in the one before.
                    r_pend <= scan_issue;
                    if (scan_issue) r_scan_idx <= r_scan_idx + 1'b1;
                    if (r_pend) r_first <= 1'b0;
                    if (scan_end) begin
                        r_min_seen <= r_lo;
                        r_max_seen <= r_hi;
                    end
                end
                S_DIV: begin
                    if (div_done) r_mean_seen <= div_quo[TIME_WIDTH-1:0];
                end
                default: r_pend <= 1'b0;
            endcase
        end
    end

    // Shared accumulate and compare unit for the window scan.
    always_ff @(posedge i_clk) begin
        if (r_state == S_SCAN && r_pend) begin
            if (r_first) begin
                r_sum <= SUM_W'(r_win_q);
                r_lo  <= r_win_q;
                r_hi  <= r_win_q;
            end else begin
                r_sum <= r_sum + SUM_W'(r_win_q);
                if (r_win_q < r_lo) r_lo <= r_win_q;
                if (r_win_q > r_hi) r_hi <= r_win_q;
            end
        end
    end

    // Start-time queue memory.
    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC && r_mode == MODE_ADD && add_ok) r_fifo_mem[r_wr_ptr] <= r_now;
        r_fifo_q <= r_fifo_mem[r_rd_ptr];
    end

    // Latency window memory.
    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC && r_mode == MODE_DECODED && dec_ok) r_win_mem[r_head] <= lat_calc;
        r_win_q <= r_win_mem[win_raddr];
    end

    // Mean over the window.
    fclm_div #(
        .DVD_W (SUM_W),
        .DVS_W (FILL_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_fill),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Output register: holds a result until its transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_o_acc    <= r_acc;
            r_o_can    <= below_limit;
            r_o_in_dec <= r_in_dec;
            r_o_done   <= r_done_cnt;
            r_o_lat    <= r_lat;
            r_o_warn   <= r_warn;
            r_o_min    <= r_min_seen;
            r_o_max    <= r_max_seen;
            r_o_avg    <= r_mean_seen;
        end
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_out_valid       = r_out_valid;
    assign o_accepted        = r_o_acc;
    assign o_can_accept      = r_o_can;
    assign o_decoding_count  = r_o_in_dec;
    assign o_decoded_count   = r_o_done;
    assign o_latency_now     = r_o_lat;
    assign o_latency_warning = r_o_warn;
    assign o_min_latency     = r_o_min;
    assign o_max_latency     = r_o_max;
    assign o_avg_latency     = r_o_avg;

    // Checks on the credit accounting, the window fill, the divider and the sequencer.
    `FCLM_ASSERT(a_total_bounded, total <= (CNT_W + 1)'(FIFO_DEPTH), "too many frames held")
    `FCLM_ASSERT(a_fill_bounded, r_fill <= FILL_W'(HISTORY_DEPTH), "window fill beyond its depth")
    `FCLM_ASSERT(a_div_in_state, !div_done || r_state == S_DIV, "divider finished outside its state")
    `FCLM_ASSERT_NEXT(a_xfer_exec, in_xfer, r_state == S_EXEC, "event transfer did not start work")
    `FCLM_ASSERT_NEXT(a_done_loads, r_state == S_DONE && out_free, o_out_valid, "result lost")

endmodule
`default_nettype wire

/* hw/rtl/fclm_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fclm_div
// Restoring unsigned divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fclm_div #(
    parameter int DVD_W = 53,
    parameter int DVS_W = 5
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DVD_W-1:0] i_dividend,
    input  wire logic [DVS_W-1:0] i_divisor,
    output logic                  o_done,
    output logic [DVD_W-1:0]      o_quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0]   trial;
    logic             take;
    logic [DVS_W:0]   diff;

    // One restoring step: shift in the next dividend bit and try to subtract.
    always_comb begin
        trial = {r_rem, r_quo[DVD_W-1]};
        take  = (trial >= {1'b0, r_dvs});
        diff  = trial - {1'b0, r_dvs};
    end

    // Control of the iteration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Partial remainder and quotient shift register.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= take ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], take};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
`default_nettype wire

/* tb/frame_credit_latency_monitor_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for frame_credit_latency_monitor_top
// Sends add, decode and release events under a series of credit limits and
// warning thresholds, with random gaps from the sender and random stalls
// from the receiver. A ledger class predicts every result and compares it,
// field by field, with what the block returns.
// ----------------------------------------------------------------------------
module frame_credit_latency_monitor_top_tb;
    import fclm_pkg::*;

    localparam int TW = TIME_WIDTH_DEF;
    localparam logic [TW-1:0] TIME_MAX = '1;

    // One result as the block reports it.
    typedef struct packed {
        logic            accepted;
        logic            can_accept;
        logic [CNT_W-1:0] decoding_count;
        logic [CNT_W-1:0] decoded_count;
        logic [TW-1:0]   latency_now;
        logic            latency_warning;
        logic [TW-1:0]   min_latency;
        logic [TW-1:0]   max_latency;
        logic [TW-1:0]   avg_latency;
    } t_frame_report;

    // Tracks credits, start times and the latency window, and holds the
    // reports still owed by the block.
    class t_credit_ledger;
        logic [CNT_W-1:0]  frame_limit;
        logic [TW-1:0]     threshold;
        logic [TW-1:0]     start_times[FIFO_DEPTH_DEF];
        int unsigned       rd_ptr;
        int unsigned       wr_ptr;
        int unsigned       in_decode;
        int unsigned       done;
        logic [TW-1:0]     window[HISTORY_DEPTH_DEF];
        int unsigned       fill;
        int unsigned       head;
        logic [TW-1:0]     lowest;
        logic [TW-1:0]     highest;
        logic [TW-1:0]     mean;
        t_frame_report     owed_reports[$];
        int unsigned       mismatches;
        int unsigned       reports_seen;
        int unsigned       events_sent[4];
        int unsigned       events_taken[4];
        int unsigned       warnings;
        int unsigned       at_limit;
        int unsigned       reg_writes;

        function new();
            frame_limit  = FRAME_LIMIT_RST;
            threshold    = LAT_THRESH_RST;
            rd_ptr       = 0;
            wr_ptr       = 0;
            in_decode    = 0;
            done         = 0;
            fill         = 0;
            head         = 0;
            lowest       = '0;
            highest      = '0;
            mean         = '0;
            mismatches   = 0;
            reports_seen = 0;
            warnings     = 0;
            at_limit     = 0;
            reg_writes   = 0;
            for (int i = 0; i < 4; i++) begin
                events_sent[i]  = 0;
                events_taken[i] = 0;
            end
        endfunction

        function void set_register(t_cfg_idx idx, logic [CFG_W-1:0] data);
            reg_writes++;
            case (idx)
                CFG_FRAME_LIMIT: frame_limit = data[CNT_W-1:0];
                CFG_LAT_THRESH:  threshold   = data[THRESH_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned outstanding();
            return owed_reports.size();
        endfunction

        // Works out the report for one transferred event and queues it.
        function void note_event(t_mode mode, logic [TW-1:0] stamp);
            t_frame_report want;
            int unsigned   cap;
            logic [63:0]   quot;
            logic [63:0]   rem;
            want = '0;
            // The start-time store bounds the credit limit.
            cap = (frame_limit > FIFO_DEPTH_DEF) ? FIFO_DEPTH_DEF : frame_limit;
            events_sent[mode]++;
            case (mode)
                MODE_ADD: begin
                    if (in_decode + done < cap) begin
                        start_times[wr_ptr] = stamp;
                        wr_ptr = (wr_ptr + 1) % FIFO_DEPTH_DEF;
                        in_decode++;
                        want.accepted = 1'b1;
                    end
                end
                MODE_DECODED: begin
                    if (in_decode != 0) begin
                        // Latency wraps with the time stamp width.
                        want.latency_now = stamp - start_times[rd_ptr];
                        rd_ptr = (rd_ptr + 1) % FIFO_DEPTH_DEF;
                        in_decode--;
                        done++;
                        want.latency_warning = (want.latency_now > threshold);
                        window[head] = want.latency_now;
                        head = (head + 1) % HISTORY_DEPTH_DEF;
                        if (fill < HISTORY_DEPTH_DEF) fill++;
                        // Min, max and a mean formed from per-entry quotients
                        // and remainders over the filled part of the window.
                        lowest  = window[0];
                        highest = window[0];
                        quot    = '0;
                        rem     = '0;
                        for (int i = 0; i < fill; i++) begin
                            if (window[i] < lowest) lowest = window[i];
                            if (window[i] > highest) highest = window[i];
                            quot = quot + window[i] / fill;
                            rem  = rem + window[i] % fill;
                        end
                        mean = quot + rem / fill;
                        want.accepted = 1'b1;
                    end
                end
                MODE_REL_REQ: want.accepted = (done != 0);
                default: begin
                    if (done != 0) begin
                        done--;
                        want.accepted = 1'b1;
                    end
                end
            endcase
            want.can_accept     = (in_decode + done < cap);
            want.decoding_count = in_decode[CNT_W-1:0];
            want.decoded_count  = done[CNT_W-1:0];
            want.min_latency    = lowest;
            want.max_latency    = highest;
            want.avg_latency    = mean;
            if (want.accepted) events_taken[mode]++;
            if (want.latency_warning) warnings++;
            if (!want.can_accept) at_limit++;
            owed_reports = {owed_reports, want};
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= 10) $display("[tb] %s", msg);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got)
                report($sformatf("report %0d: %s expected 0x%0h, got 0x%0h",
                                 reports_seen, name, want, got));
        endfunction

        // Compares one report from the block with the oldest one owed.
        function void check_result(t_frame_report got);
            t_frame_report want;
            if (owed_reports.size() == 0) begin
                report("report arrived with no event outstanding");
                return;
            end
            want = owed_reports[0];
            owed_reports.delete(0);
            reports_seen++;
            compare_field("accepted", want.accepted, got.accepted);
            compare_field("can_accept", want.can_accept, got.can_accept);
            compare_field("decoding_count", want.decoding_count, got.decoding_count);
            compare_field("decoded_count", want.decoded_count, got.decoded_count);
            compare_field("latency_now", want.latency_now, got.latency_now);
            compare_field("latency_warning", want.latency_warning, got.latency_warning);
            compare_field("min_latency", want.min_latency, got.min_latency);
            compare_field("max_latency", want.max_latency, got.max_latency);
            compare_field("avg_latency", want.avg_latency, got.avg_latency);
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [0:0]           i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [1:0]           i_mode;
    logic [TW-1:0]        i_now_time;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic                 o_accepted;
    logic                 o_can_accept;
    logic [CNT_W-1:0]     o_decoding_count;
    logic [CNT_W-1:0]     o_decoded_count;
    logic [TW-1:0]        o_latency_now;
    logic                 o_latency_warning;
    logic [TW-1:0]        o_min_latency;
    logic [TW-1:0]        o_max_latency;
    logic [TW-1:0]        o_avg_latency;

    t_credit_ledger ledger = new();

    // Sender burst state and the running time stamp.
    int unsigned   burst_left = 0;
    bit            gaps_on = 1'b1;
    logic [TW-1:0] clock_us = '0;

    // Receiver stall pattern state.
    int unsigned   stall_style = 0;
    int unsigned   style_left = 0;
    int unsigned   run_left = 0;
    bit            run_stalled = 1'b0;

    frame_credit_latency_monitor_top u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_mode            (i_mode),
        .i_now_time        (i_now_time),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_accepted        (o_accepted),
        .o_can_accept      (o_can_accept),
        .o_decoding_count  (o_decoding_count),
        .o_decoded_count   (o_decoded_count),
        .o_latency_now     (o_latency_now),
        .o_latency_warning (o_latency_warning),
        .o_min_latency     (o_min_latency),
        .o_max_latency     (o_max_latency),
        .o_avg_latency     (o_avg_latency)
    );

    always #5 i_clk = ~i_clk;

    // Receiver: no stalls, scattered stalls or long stall runs, switching
    // style whenever its style countdown runs out.
    always @(negedge i_clk) begin
        if (style_left == 0) begin
            stall_style = $urandom_range(0, 2);
            style_left  = 300;
        end else begin
            style_left--;
        end
        case (stall_style)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 2) == 0);
            default: begin
                if (run_left == 0) begin
                    run_stalled = !run_stalled;
                    run_left    = run_stalled ? $urandom_range(1, 20) : $urandom_range(1, 10);
                end else begin
                    run_left--;
                end
                i_out_stall <= run_stalled;
            end
        endcase
    end

    // Check every report transfer against the ledger.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            ledger.check_result('{o_accepted, o_can_accept, o_decoding_count,
                                  o_decoded_count, o_latency_now, o_latency_warning,
                                  o_min_latency, o_max_latency, o_avg_latency});
    end

    function automatic logic [TW-1:0] rand_stamp();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        return raw[TW-1:0];
    endfunction

    // Mostly small steps forward, now and then a jump anywhere or to just
    // below the wrap point.
    function automatic logic [TW-1:0] next_stamp();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick == 0) clock_us = rand_stamp();
        else if (pick == 1) clock_us = TIME_MAX - $urandom_range(0, 2000000);
        else clock_us = clock_us + $urandom_range(0, 600000);
        return clock_us;
    endfunction

    // Starts and ends at a falling edge.
    task automatic issue_event(t_mode mode, logic [TW-1:0] stamp);
        if (burst_left == 0) begin
            if (gaps_on) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_mode     <= mode;
        i_now_time <= stamp;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        ledger.note_event(mode, stamp);
        @(negedge i_clk);
    endtask

    // Stop sending and wait until every report has come back.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (ledger.outstanding() != 0) @(negedge i_clk);
    endtask

    task automatic write_register(t_cfg_idx idx, logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        ledger.set_register(idx, data);
    endtask

    // One random phase: new settings, then a weighted mix of events. The
    // release-fired weight is whatever remains of 100.
    task automatic run_phase(int unsigned limit, logic [TW-1:0] thresh, int unsigned add_w,
                             int unsigned dec_w, int unsigned req_w, bit gaps,
                             int unsigned n_items);
        logic [CFG_W-1:0] limit_word;
        int unsigned      pick;
        t_mode            mode;
        settle();
        limit_word = rand_stamp();
        limit_word[CNT_W-1:0] = limit[CNT_W-1:0];
        write_register(CFG_FRAME_LIMIT, limit_word);
        write_register(CFG_LAT_THRESH, thresh);
        gaps_on = gaps;
        repeat (n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < add_w) mode = MODE_ADD;
            else if (pick < add_w + dec_w) mode = MODE_DECODED;
            else if (pick < add_w + dec_w + req_w) mode = MODE_REL_REQ;
            else mode = MODE_REL_FIRED;
            issue_event(mode, next_stamp());
        end
    endtask

    // Hard stop in case the block hangs.
    initial begin
        #10_000_000;
        $display("[frame_credit_latency_monitor_top] ERROR");
        $finish;
    end

    initial begin
        int unsigned waited;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_FRAME_LIMIT;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_mode      = MODE_ADD;
        i_now_time  = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Settings after reset: refusals on an empty block, wrapped
        // latencies and the warning just either side of the threshold.
        issue_event(MODE_DECODED, '0);
        issue_event(MODE_REL_REQ, '0);
        issue_event(MODE_REL_FIRED, '0);
        issue_event(MODE_ADD, '0);
        issue_event(MODE_ADD, TIME_MAX - 15);
        issue_event(MODE_ADD, TIME_MAX);
        issue_event(MODE_DECODED, 48'd1000000);
        issue_event(MODE_DECODED, 48'h10);
        issue_event(MODE_DECODED, '0);
        issue_event(MODE_ADD, 48'd5);
        issue_event(MODE_DECODED, 48'd1000006);
        issue_event(MODE_REL_REQ, 48'd1000006);
        repeat (5) issue_event(MODE_REL_FIRED, 48'd1000007);

        // Limit of one with a zero threshold: a zero latency must not warn.
        settle();
        write_register(CFG_FRAME_LIMIT, 48'd1);
        write_register(CFG_LAT_THRESH, '0);
        issue_event(MODE_ADD, 48'd100);
        issue_event(MODE_ADD, 48'd200);
        issue_event(MODE_DECODED, 48'd100);
        issue_event(MODE_ADD, 48'd300);
        issue_event(MODE_REL_FIRED, 48'd300);

        // Limit of zero refuses every add.
        settle();
        write_register(CFG_FRAME_LIMIT, '0);
        write_register(CFG_LAT_THRESH, '1);
        issue_event(MODE_ADD, 48'd400);

        // Limit above the store (all ones, masked to 127), largest latency
        // against the largest threshold.
        settle();
        write_register(CFG_FRAME_LIMIT, '1);
        issue_event(MODE_ADD, '0);
        issue_event(MODE_DECODED, TIME_MAX);

        // Random phases across limits, thresholds and traffic mixes.
        run_phase(64, LAT_THRESH_RST, 35, 30, 5, 1'b1, 200);
        run_phase(1, $urandom_range(0, 3000000), 40, 30, 10, 1'b1, 200);
        run_phase(127, '0, 55, 20, 5, 1'b0, 250);
        run_phase(127, 48'd1200000, 15, 40, 10, 1'b1, 200);
        run_phase(0, TIME_MAX, 40, 30, 5, 1'b1, 100);
        run_phase(2, LAT_THRESH_RST, 35, 30, 10, 1'b1, 200);
        run_phase($urandom_range(1, 63), rand_stamp(), 45, 25, 5, 1'b1, 250);
        run_phase($urandom_range(65, 127), $urandom_range(0, 3000000), 60, 15, 5, 1'b0, 250);
        run_phase(64, TIME_MAX, 20, 35, 10, 1'b1, 200);
        run_phase(3, '0, 35, 30, 10, 1'b1, 150);

        // Let the last reports drain, then allow for a slow decode.
        i_in_valid <= 1'b0;
        waited = 0;
        while (ledger.outstanding() != 0 && waited < 20000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (100) @(negedge i_clk);
        if (ledger.outstanding() != 0)
            ledger.report($sformatf("%0d reports never arrived", ledger.outstanding()));

        $display("[tb] %0d events; add %0d/%0d dec %0d/%0d req %0d/%0d rel %0d/%0d taken",
                 ledger.reports_seen,
                 ledger.events_taken[MODE_ADD], ledger.events_sent[MODE_ADD],
                 ledger.events_taken[MODE_DECODED], ledger.events_sent[MODE_DECODED],
                 ledger.events_taken[MODE_REL_REQ], ledger.events_sent[MODE_REL_REQ],
                 ledger.events_taken[MODE_REL_FIRED], ledger.events_sent[MODE_REL_FIRED]);
        $display("[tb] %0d register writes, %0d warnings, %0d at the limit, %0d mismatches",
                 ledger.reg_writes, ledger.warnings, ledger.at_limit, ledger.mismatches);
        if (ledger.mismatches == 0)
            $display("[frame_credit_latency_monitor_top] OK");
        else
            $display("[frame_credit_latency_monitor_top] ERROR");
        $finish;
    end

endmodule
